// ===== design/xrg_pkg.sv =====
// Package: shared types and constants of the xoshiro256** random generator.
`default_nettype none

package xrg_pkg;

	// splitmix64 seeding constants
	localparam logic [63:0] SM_GAMMA = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] SM_MUL1  = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [63:0] SM_MUL2  = 64'h94d0_49bb_1331_11eb;

	// operation codes of an input transaction
	localparam logic OP_SEED = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	// controller states
	typedef enum logic [4:0] {
		S_IDLE,
		S_SM_ADD,
		S_M1_LL,
		S_M1_LH,
		S_M1_HL,
		S_M1_END,
		S_MIX27,
		S_M2_LL,
		S_M2_LH,
		S_M2_HL,
		S_M2_END,
		S_STORE,
		S_ADVANCE,
		S_RAW,
		S_SC_HI,
		S_SC_LO,
		S_SC_END,
		S_PUT
	} ctl_state_t;

	// datapath step commanded by the controller
	typedef enum logic [3:0] {
		DP_NOP,
		DP_SM_ADD,
		DP_MUL_LL,
		DP_MUL_LH,
		DP_MUL_HL,
		DP_MUL_END,
		DP_MIX27,
		DP_STORE,
		DP_ADVANCE,
		DP_RAW,
		DP_SC_HI,
		DP_SC_LO,
		DP_SC_END,
		DP_PUT
	} dp_step_t;

	// which splitmix64 multiplier constant feeds the multiplier
	typedef enum logic {
		SMC_MUL1,
		SMC_MUL2
	} sm_const_t;

	// command from controller to datapath
	typedef struct packed {
		logic      load;
		dp_step_t  step;
		sm_const_t mul_const;
		logic [1:0] word_idx;
	} dp_cmd_t;

endpackage

`default_nettype wire

// ===== design/xrg_if.sv =====
// Interfaces: input and result channels of the random generator.
`default_nettype none

interface xrg_in_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic [63:0]        seed_value;
	logic signed [31:0] range_bound;

	modport source(output valid, output operation, output seed_value, output range_bound,
		input ready);
	modport sink(input valid, input operation, input seed_value, input range_bound,
		output ready);
endinterface

interface xrg_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] raw_value;
	logic [52:0] unit_fraction;
	logic [30:0] bounded_integer;

	modport source(output valid, output raw_value, output unit_fraction,
		output bounded_integer, input ready);
	modport sink(input valid, input raw_value, input unit_fraction,
		input bounded_integer, output ready);
endinterface

`default_nettype wire

// ===== design/xrg_ctl.sv =====
// Controller: sequences seeding and draws and owns the result-valid flag.
`default_nettype none

module xrg_ctl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_operation,
	input  logic             rsp_ready,
	output logic             req_ready,
	output logic             rsp_valid,
	output xrg_pkg::dp_cmd_t cmd
);

	xrg_pkg::ctl_state_t state_q, state_d;
	logic [1:0]          cnt_q, cnt_d;
	logic                out_valid_q, out_valid_d;

	// state, word counter and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= xrg_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	// next state and datapath command
	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		out_valid_d   = out_valid_q && !rsp_ready;
		req_ready     = 1'b0;
		cmd.load      = 1'b0;
		cmd.step      = xrg_pkg::DP_NOP;
		cmd.mul_const = xrg_pkg::SMC_MUL1;
		cmd.word_idx  = cnt_q;
		case (state_q)
			xrg_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					if (req_operation == xrg_pkg::OP_DRAW) begin
						state_d = xrg_pkg::S_ADVANCE;
					end else begin
						state_d = xrg_pkg::S_SM_ADD;
					end
				end
			end
			xrg_pkg::S_SM_ADD: begin
				cmd.step = xrg_pkg::DP_SM_ADD;
				state_d  = xrg_pkg::S_M1_LL;
			end
			xrg_pkg::S_M1_LL: begin
				cmd.step = xrg_pkg::DP_MUL_LL;
				state_d  = xrg_pkg::S_M1_LH;
			end
			xrg_pkg::S_M1_LH: begin
				cmd.step = xrg_pkg::DP_MUL_LH;
				state_d  = xrg_pkg::S_M1_HL;
			end
			xrg_pkg::S_M1_HL: begin
				cmd.step = xrg_pkg::DP_MUL_HL;
				state_d  = xrg_pkg::S_M1_END;
			end
			xrg_pkg::S_M1_END: begin
				cmd.step = xrg_pkg::DP_MUL_END;
				state_d  = xrg_pkg::S_MIX27;
			end
			xrg_pkg::S_MIX27: begin
				cmd.step = xrg_pkg::DP_MIX27;
				state_d  = xrg_pkg::S_M2_LL;
			end
			xrg_pkg::S_M2_LL: begin
				cmd.step      = xrg_pkg::DP_MUL_LL;
				cmd.mul_const = xrg_pkg::SMC_MUL2;
				state_d       = xrg_pkg::S_M2_LH;
			end
			xrg_pkg::S_M2_LH: begin
				cmd.step      = xrg_pkg::DP_MUL_LH;
				cmd.mul_const = xrg_pkg::SMC_MUL2;
				state_d       = xrg_pkg::S_M2_HL;
			end
			xrg_pkg::S_M2_HL: begin
				cmd.step      = xrg_pkg::DP_MUL_HL;
				cmd.mul_const = xrg_pkg::SMC_MUL2;
				state_d       = xrg_pkg::S_M2_END;
			end
			xrg_pkg::S_M2_END: begin
				cmd.step      = xrg_pkg::DP_MUL_END;
				cmd.mul_const = xrg_pkg::SMC_MUL2;
				state_d       = xrg_pkg::S_STORE;
			end
			xrg_pkg::S_STORE: begin
				cmd.step = xrg_pkg::DP_STORE;
				cnt_d    = cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					state_d = xrg_pkg::S_IDLE;
				end else begin
					state_d = xrg_pkg::S_SM_ADD;
				end
			end
			xrg_pkg::S_ADVANCE: begin
				cmd.step = xrg_pkg::DP_ADVANCE;
				state_d  = xrg_pkg::S_RAW;
			end
			xrg_pkg::S_RAW: begin
				cmd.step = xrg_pkg::DP_RAW;
				state_d  = xrg_pkg::S_SC_HI;
			end
			xrg_pkg::S_SC_HI: begin
				cmd.step = xrg_pkg::DP_SC_HI;
				state_d  = xrg_pkg::S_SC_LO;
			end
			xrg_pkg::S_SC_LO: begin
				cmd.step = xrg_pkg::DP_SC_LO;
				state_d  = xrg_pkg::S_SC_END;
			end
			xrg_pkg::S_SC_END: begin
				cmd.step = xrg_pkg::DP_SC_END;
				state_d  = xrg_pkg::S_PUT;
			end
			xrg_pkg::S_PUT: begin
				// hold until the result register is free
				if (!out_valid_q || rsp_ready) begin
					cmd.step    = xrg_pkg::DP_PUT;
					out_valid_d = 1'b1;
					state_d     = xrg_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = xrg_pkg::S_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== design/xrg_dp.sv =====
// Datapath: generator state, shared 32x32 multiplier and result registers.
`default_nettype none

module xrg_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  xrg_pkg::dp_cmd_t   cmd,
	input  logic [63:0]        seed_value,
	input  logic signed [31:0] range_bound,
	output logic [63:0]        raw_value,
	output logic [52:0]        unit_fraction,
	output logic [30:0]        bounded_integer
);

	logic [63:0] gen_q [4];
	logic [63:0] seed_q;
	logic [30:0] bound_q;
	logic [63:0] x_q;
	logic [63:0] z_q;
	logic [63:0] prod_q;
	logic [63:0] raw_q;
	logic [63:0] out_raw_q;
	logic [30:0] out_bint_q;

	logic [63:0] mul_c;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [63:0] seed_sum;
	logic [63:0] rot7;
	logic [63:0] w2_x;
	logic [63:0] w3_x;

	// pick the seeding multiplier constant
	always_comb begin
		case (cmd.mul_const)
			xrg_pkg::SMC_MUL1: mul_c = xrg_pkg::SM_MUL1;
			xrg_pkg::SMC_MUL2: mul_c = xrg_pkg::SM_MUL2;
			default:           mul_c = xrg_pkg::SM_MUL1;
		endcase
	end

	// select multiplier operands for the current step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.step)
			xrg_pkg::DP_MUL_LL: begin
				mul_a = x_q[31:0];
				mul_b = mul_c[31:0];
			end
			xrg_pkg::DP_MUL_LH: begin
				mul_a = x_q[31:0];
				mul_b = mul_c[63:32];
			end
			xrg_pkg::DP_MUL_HL: begin
				mul_a = x_q[63:32];
				mul_b = mul_c[31:0];
			end
			xrg_pkg::DP_SC_HI: begin
				// upper 32 bits of the fraction
				mul_a = raw_q[63:32];
				mul_b = {1'b0, bound_q};
			end
			xrg_pkg::DP_SC_LO: begin
				// lower 21 bits of the fraction
				mul_a = {11'd0, raw_q[31:11]};
				mul_b = {1'b0, bound_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p    = mul_a * mul_b;
	assign seed_sum = seed_q + xrg_pkg::SM_GAMMA;
	assign rot7     = {x_q[56:0], x_q[63:57]};
	assign w2_x     = gen_q[2] ^ gen_q[0];
	assign w3_x     = gen_q[3] ^ gen_q[1];

	// generator state words: seed stores and xoshiro256** advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				gen_q[i] <= '0;
			end
		end else begin
			case (cmd.step)
				xrg_pkg::DP_STORE: begin
					gen_q[cmd.word_idx] <= z_q ^ (z_q >> 31);
				end
				xrg_pkg::DP_ADVANCE: begin
					gen_q[0] <= gen_q[0] ^ w3_x;
					gen_q[1] <= gen_q[1] ^ w2_x;
					gen_q[2] <= w2_x ^ {gen_q[1][46:0], 17'd0};
					gen_q[3] <= {w3_x[18:0], w3_x[63:19]};
				end
				default: begin
				end
			endcase
		end
	end

	// working registers and result registers
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (cmd.load) begin
			seed_q  <= seed_value;
			bound_q <= range_bound[31] ? 31'd0 : range_bound[30:0];
		end
		case (cmd.step)
			xrg_pkg::DP_SM_ADD: begin
				seed_q <= seed_sum;
				x_q    <= seed_sum ^ (seed_sum >> 30);
			end
			xrg_pkg::DP_MUL_LH: begin
				z_q <= prod_q;
			end
			xrg_pkg::DP_MUL_HL, xrg_pkg::DP_MUL_END: begin
				z_q[63:32] <= z_q[63:32] + prod_q[31:0];
			end
			xrg_pkg::DP_MIX27: begin
				x_q <= z_q ^ (z_q >> 27);
			end
			xrg_pkg::DP_ADVANCE: begin
				// times five
				x_q <= gen_q[1] + {gen_q[1][61:0], 2'd0};
			end
			xrg_pkg::DP_RAW: begin
				// rotate by seven, then times nine
				raw_q <= rot7 + {rot7[60:0], 3'd0};
			end
			xrg_pkg::DP_SC_LO: begin
				z_q <= prod_q;
			end
			xrg_pkg::DP_SC_END: begin
				z_q <= z_q + {21'd0, prod_q[63:21]};
			end
			xrg_pkg::DP_PUT: begin
				out_raw_q  <= raw_q;
				out_bint_q <= z_q[62:32];
			end
			default: begin
			end
		endcase
	end

	assign raw_value       = out_raw_q;
	assign unit_fraction   = out_raw_q[63:11];
	assign bounded_integer = out_bint_q;

endmodule

`default_nettype wire

// ===== design/xoshiro256ss_random_generator.sv =====
// Top level: xoshiro256** random generator with splitmix64 seeding.
//
//   channel  dir  payload                                         
//   req      in   operation, seed_value, range_bound              
//   rsp      out  raw_value, unit_fraction, bounded_integer       
//
// A seed transaction is accepted, then each state word goes through splitmix64
// add, two 64-bit constant multiplies on the shared 32x32 multiplier (low-low,
// low-high, high-low partial products and an end step), mix and store. A draw
// goes through accept, advance, output word, two partial products for the
// bounded integer, accumulate and load result. One transaction is in work at a
// time. The result register lets the next transaction in while a result waits;
// a draw holds in its last step while that register is still full.
// arst_n clears the state words to zero and the controller to idle.
`default_nettype none

module xoshiro256ss_random_generator (
	input logic       clk,
	input logic       arst_n,
	xrg_in_if.sink    req,
	xrg_out_if.source rsp
);

	xrg_pkg::dp_cmd_t cmd;

	xrg_ctl u_ctl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req.valid),
		.req_operation (req.operation),
		.rsp_ready     (rsp.ready),
		.req_ready     (req.ready),
		.rsp_valid     (rsp.valid),
		.cmd           (cmd)
	);

	xrg_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.seed_value      (req.seed_value),
		.range_bound     (req.range_bound),
		.raw_value       (rsp.raw_value),
		.unit_fraction   (rsp.unit_fraction),
		.bounded_integer (rsp.bounded_integer)
	);

endmodule

`default_nettype wire

// ===== design/xrg_chk.sv =====
// Checker: port-level assertions for the random generator, bound to the top.
`default_nettype none

module xrg_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        req_operation,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [63:0] rsp_raw_value,
	input logic [52:0] rsp_unit_fraction
);

	// a stalled result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// the fraction is the top 53 bits of the output word
	a_frac: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_unit_fraction == rsp_raw_value[63:11])
		else $error("fraction does not match output word");

	// an accepted transaction keeps the input busy while it is worked
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("input taken on consecutive cycles");

	// a seed transaction never produces a result
	a_seed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_operation == xrg_pkg::OP_SEED && !rsp_valid
		|=> !rsp_valid)
		else $error("result after seed");

endmodule

bind xoshiro256ss_random_generator xrg_chk u_xrg_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.req_operation     (req.operation),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_raw_value     (rsp.raw_value),
	.rsp_unit_fraction (rsp.unit_fraction)
);

`default_nettype wire
